// File: hw/rtl/bpc_pkg.sv
// bpc_pkg: shared constants and types for the barometric pressure compensation block
// no dependencies
`default_nettype none
package bpc_pkg;
   localparam int unsigned CntWidth  = 6;

   // register indexes
   localparam logic [2:0] REG_AC1_AC2 = 3'd0;
   localparam logic [2:0] REG_AC3_AC4 = 3'd1;
   localparam logic [2:0] REG_AC5_AC6 = 3'd2;
   localparam logic [2:0] REG_B1_B2   = 3'd3;
   localparam logic [2:0] REG_MC_MD   = 3'd4;

   // item opcodes
   localparam logic OP_TEMP  = 1'b0;
   localparam logic OP_PRESS = 1'b1;

   // divider request and status between sequencer and divider
   typedef struct packed {
      logic        start;
      logic        signed_div;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;
endpackage
`default_nettype wire

// File: hw/rtl/barometric_pressure_compensation.sv
// barometric_pressure_compensation: integer compensation of raw temperature and pressure
// temperature and pressure results come from the shared bit-serial multiplier and divider;
// a zero temperature divisor or a zero b4 skips the divide
// throughput: one item at a time, the next taken in the cycle after the result is accepted
// reset: synchronous; clears calibration registers, stored b5 term and all control state
// depends on bpc_pkg, bpc_mul, bpc_div
`default_nettype none
module barometric_pressure_compensation (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_opcode,
   input  wire logic [15:0] req_raw_reading,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_result_kind,
   output logic [31:0]      rsp_compensated_value,
   output logic             rsp_divide_fault,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   // sequencer steps
   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_T1    = 5'd1;  // x1 = (ut-ac6)*ac5
   localparam logic [4:0] S_T2    = 5'd2;  // num = mc*2048, divide
   localparam logic [4:0] S_T3    = 5'd3;  // wait divide
   localparam logic [4:0] S_P1    = 5'd4;  // b6*b6
   localparam logic [4:0] S_P2    = 5'd5;  // b2*sq
   localparam logic [4:0] S_P3    = 5'd6;  // ac2*b6
   localparam logic [4:0] S_P4    = 5'd7;  // ac3*b6
   localparam logic [4:0] S_P5    = 5'd8;  // b1*sq
   localparam logic [4:0] S_P6    = 5'd9;  // ac4*(x3+32768)
   localparam logic [4:0] S_P7    = 5'd10; // (up-b3)*50000
   localparam logic [4:0] S_P8    = 5'd11; // divide
   localparam logic [4:0] S_P9    = 5'd12; // (p>>8)^2
   localparam logic [4:0] S_P10   = 5'd13; // x1*3038
   localparam logic [4:0] S_P11   = 5'd14; // p*-7357
   localparam logic [4:0] S_OUT   = 5'd15;

   logic [31:0] ac12_ff, ac34_ff, ac56_ff, b12_ff, mcmd_ff;
   logic [31:0] b5_ff, b5_in;
   logic [4:0]  st_ff, st_in;
   logic        go_ff, go_in;      // launch pending for current step
   logic        op_ff, op_in;
   logic [15:0] raw_ff, raw_in;
   logic [31:0] ra_ff, ra_in, rb_ff, rb_in, rc_ff, rc_in, rd_ff, rd_in, re_ff, re_in;
   logic        ov_ff, ov_in;
   logic [31:0] val_ff, val_in;
   logic        flt_ff, flt_in;
   logic        kind_ff, kind_in;

   logic        mstart, mbusy, mdone;
   logic [31:0] ma, mb, mp;
   bpc_pkg::div_req_type dreq;
   bpc_pkg::div_rsp_type drsp;

   bpc_mul u_mul (.clock(clock), .reset(reset), .start(mstart), .op_a(ma), .op_b(mb),
                  .busy(mbusy), .done(mdone), .product(mp));
   bpc_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   // calibration fields
   logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   assign ac1 = {{16{ac12_ff[31]}}, ac12_ff[31:16]};
   assign ac2 = {{16{ac12_ff[15]}}, ac12_ff[15:0]};
   assign ac3 = {{16{ac34_ff[31]}}, ac34_ff[31:16]};
   assign ac4 = {16'd0, ac34_ff[15:0]};
   assign ac5 = {16'd0, ac56_ff[31:16]};
   assign ac6 = {16'd0, ac56_ff[15:0]};
   assign b1  = {{16{b12_ff[31]}}, b12_ff[31:16]};
   assign b2  = {{16{b12_ff[15]}}, b12_ff[15:0]};
   assign mc  = {{16{mcmd_ff[31]}}, mcmd_ff[31:16]};
   assign md  = {{16{mcmd_ff[15]}}, mcmd_ff[15:0]};

   logic rsp_valid_ff, rsp_valid_in;
   logic busy_out;
   assign busy_out  = rsp_valid_ff;

   // csr access
   logic csr_wr;
   assign csr_wr = psel && penable && pwrite;
   assign pready = 1'b1;
   always_comb begin
      unique case (paddr[4:2])
         bpc_pkg::REG_AC1_AC2: prdata = ac12_ff;
         bpc_pkg::REG_AC3_AC4: prdata = ac34_ff;
         bpc_pkg::REG_AC5_AC6: prdata = ac56_ff;
         bpc_pkg::REG_B1_B2:   prdata = b12_ff;
         bpc_pkg::REG_MC_MD:   prdata = mcmd_ff;
         default:              prdata = '0;
      endcase
   end

   assign req_ready = (st_ff == S_IDLE) && !rsp_valid_ff;

   // temporaries used by several steps
   logic [31:0] x1t, dent, numt, x3a, b3t, x3b, b7t, pt, sum_t;
   always_comb begin
      x1t  = $signed(mp) >>> 15;
      numt = {mc[20:0], 11'd0};
      dent = ra_ff + md;
      x3a  = ($signed(rc_ff) >>> 11) + ($signed(mp) >>> 11);
      b3t  = $signed({ac1[29:0], 2'b00} + x3a + 32'd2) >>> 2;
      x3b  = $signed(($signed(rd_ff) >>> 13) + ($signed(mp) >>> 16) + 32'sd2) >>> 2;
      b7t  = {16'd0, raw_ff} - ra_ff;
      pt   = drsp.quotient;
      sum_t = ($signed(rc_ff) >>> 16) + ($signed(mp) >>> 16) + 32'sd3791;
   end

   // sequencer: at most one multiply or divide per step
   always_comb begin
      st_in = st_ff; go_in = 1'b0; op_in = op_ff; raw_in = raw_ff;
      ra_in = ra_ff; rb_in = rb_ff; rc_in = rc_ff; rd_in = rd_ff; re_in = re_ff;
      ov_in = ov_ff; val_in = val_ff; flt_in = flt_ff; kind_in = kind_ff;
      b5_in = b5_ff; rsp_valid_in = rsp_valid_ff;
      mstart = 1'b0; ma = '0; mb = '0;
      dreq = '0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      unique case (st_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               op_in = req_opcode; raw_in = req_raw_reading;
               st_in = (req_opcode == bpc_pkg::OP_TEMP) ? S_T1 : S_P1;
               go_in = 1'b1;
               ra_in = b5_ff - 32'd4000; // b6
            end
         end
         S_T1: begin
            mstart = go_ff; ma = {16'd0, raw_ff} - ac6; mb = ac5;
            if (mdone) begin
               ra_in = x1t;
               st_in = S_T2; go_in = 1'b1;
            end
         end
         S_T2: begin
            if (dent == 32'd0) begin
               val_in = numt[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
               flt_in = 1'b1; st_in = S_OUT;
            end else begin
               dreq.start = 1'b1; dreq.signed_div = 1'b1;
               dreq.dividend = numt; dreq.divisor = dent;
               st_in = S_T3;
            end
         end
         S_T3: begin
            if (drsp.done) begin
               b5_in = ra_ff + pt;
               val_in = $signed(ra_ff + pt + 32'd8) >>> 4;
               flt_in = 1'b0; st_in = S_OUT;
            end
         end
         S_P1: begin
            mstart = go_ff; ma = ra_ff; mb = ra_ff;
            if (mdone) begin rb_in = $signed(mp) >>> 12; st_in = S_P2; go_in = 1'b1; end
         end
         S_P2: begin
            mstart = go_ff; ma = b2; mb = rb_ff;
            if (mdone) begin rc_in = mp; st_in = S_P3; go_in = 1'b1; end
         end
         S_P3: begin
            mstart = go_ff; ma = ac2; mb = ra_ff;
            if (mdone) begin re_in = b3t; st_in = S_P4; go_in = 1'b1; end
         end
         S_P4: begin
            mstart = go_ff; ma = ac3; mb = ra_ff;
            if (mdone) begin rd_in = mp; st_in = S_P5; go_in = 1'b1; end
         end
         S_P5: begin
            mstart = go_ff; ma = b1; mb = rb_ff;
            if (mdone) begin rd_in = x3b; st_in = S_P6; go_in = 1'b1; end
         end
         S_P6: begin
            mstart = go_ff; ma = ac4; mb = rd_ff + 32'd32768;
            if (mdone) begin rb_in = {15'd0, mp[31:15]}; st_in = S_P7; go_in = 1'b1; end
         end
         S_P7: begin
            mstart = go_ff; ma = {16'd0, raw_ff} - re_ff; mb = 32'd50000;
            if (mdone) begin rc_in = mp; st_in = S_P8; go_in = 1'b1; end
         end
         S_P8: begin
            if (go_ff) begin
               if (rb_ff == 32'd0) begin
                  val_in = 32'h7FFF_FFFF; flt_in = 1'b1; st_in = S_OUT;
               end else begin
                  dreq.start = 1'b1; dreq.signed_div = 1'b0;
                  dreq.dividend = rc_ff[31] ? rc_ff : {rc_ff[30:0], 1'b0};
                  dreq.divisor = rb_ff;
                  ov_in = rc_ff[31];
               end
            end else if (drsp.done) begin
               rd_in = ov_ff ? {pt[30:0], 1'b0} : pt;
               st_in = S_P9; go_in = 1'b1;
            end
         end
         S_P9: begin
            mstart = go_ff;
            ma = $signed(rd_ff) >>> 8; mb = $signed(rd_ff) >>> 8;
            if (mdone) begin rc_in = mp; st_in = S_P10; go_in = 1'b1; end
         end
         S_P10: begin
            mstart = go_ff; ma = rc_ff; mb = 32'd3038;
            if (mdone) begin rc_in = mp; st_in = S_P11; go_in = 1'b1; end
         end
         S_P11: begin
            mstart = go_ff; ma = rd_ff; mb = 32'd0 - 32'd7357;
            if (mdone) begin
               val_in = $signed(rd_ff) + ($signed(sum_t) >>> 4);
               flt_in = 1'b0; st_in = S_OUT;
            end
         end
         S_OUT: begin
            kind_in = op_ff; rsp_valid_in = 1'b1; st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; go_ff <= 1'b0; rsp_valid_ff <= 1'b0;
         ac12_ff <= '0; ac34_ff <= '0; ac56_ff <= '0; b12_ff <= '0; mcmd_ff <= '0;
         b5_ff <= '0;
      end else begin
         st_ff <= st_in; go_ff <= go_in; rsp_valid_ff <= rsp_valid_in;
         b5_ff <= b5_in;
         if (csr_wr) begin
            unique case (paddr[4:2])
               bpc_pkg::REG_AC1_AC2: ac12_ff <= pwdata;
               bpc_pkg::REG_AC3_AC4: ac34_ff <= pwdata;
               bpc_pkg::REG_AC5_AC6: ac56_ff <= pwdata;
               bpc_pkg::REG_B1_B2:   b12_ff  <= pwdata;
               bpc_pkg::REG_MC_MD:   mcmd_ff <= pwdata;
               default: ;
            endcase
         end
      end
      op_ff <= op_in; raw_ff <= raw_in; ov_ff <= ov_in;
      ra_ff <= ra_in; rb_ff <= rb_in; rc_ff <= rc_in; rd_ff <= rd_in; re_ff <= re_in;
      val_ff <= val_in; flt_ff <= flt_in; kind_ff <= kind_in;
   end

   assign rsp_valid             = busy_out;
   assign rsp_result_kind       = kind_ff;
   assign rsp_compensated_value = val_ff;
   assign rsp_divide_fault      = flt_ff;

   logic unused_busy;
   assign unused_busy = mbusy ^ drsp.busy ^ paddr[0] ^ paddr[1] ^ (|b7t);
endmodule
`default_nettype wire

// File: hw/rtl/bpc_mul.sv
// bpc_mul: bit-serial 32x32 multiplier, low 32 bits of the product, one bit per cycle
// depends on bpc_pkg
`default_nettype none
module bpc_mul (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] op_a,
   input  wire logic [31:0] op_b,
   output logic             busy,
   output logic             done,
   output logic [31:0]      product
);
   logic [31:0] acc_ff, acc_in;
   logic [31:0] mcand_ff, mcand_in;
   logic [31:0] mplier_ff, mplier_in;
   logic [bpc_pkg::CntWidth-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;

   // shift-add, one multiplier bit per cycle
   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         acc_in    = '0;
         mcand_in  = op_a;
         mplier_in = op_b;
         cnt_in    = '0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         if (mplier_ff[0]) acc_in = acc_ff + mcand_ff;
         mcand_in  = {mcand_ff[30:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[31:1]};
         cnt_in    = cnt_ff + 1'b1;
         if (cnt_ff == bpc_pkg::CntWidth'(31)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign busy    = busy_ff;
   assign done    = done_ff;
   assign product = acc_ff;
endmodule
`default_nettype wire

// File: hw/rtl/bpc_div.sv
// bpc_div: radix-2 restoring divider, signed or unsigned truncating, one bit per cycle
// depends on bpc_pkg; divisor is never zero when started
`default_nettype none
module bpc_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bpc_pkg::div_req_type req,
   output bpc_pkg::div_rsp_type      rsp
);
   logic [31:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic        neg_ff, neg_in;
   logic [bpc_pkg::CntWidth-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [32:0] trial;
   logic [31:0] abs_a, abs_b;

   always_comb begin
      abs_a = (req.signed_div && req.dividend[31]) ? (~req.dividend + 1'b1) : req.dividend;
      abs_b = (req.signed_div && req.divisor[31]) ? (~req.divisor + 1'b1) : req.divisor;
      trial = {rem_ff, quo_ff[31]} - {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         quo_in  = abs_a;
         rem_in  = '0;
         dvs_in  = abs_b;
         neg_in  = req.signed_div && (req.dividend[31] ^ req.divisor[31]);
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // one quotient bit per cycle; the partial remainder stays below the divisor
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[30:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == bpc_pkg::CntWidth'(31)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
endmodule
`default_nettype wire

// File: hw/rtl/bpc_checker.sv
// bpc_checker: port-level assertions for the compensation block
// bound to barometric_pressure_compensation
`default_nettype none
module bpc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_compensated_value,
   input wire logic        rsp_divide_fault,
   input wire logic        rsp_result_kind
);
   // no new item while a result waits
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("item accepted with result pending");
   // a result never follows its item in the next cycle
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid) else $error("result too early");
   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_compensated_value))
      else $error("result dropped");
   // fault on pressure always saturates high
   a_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_divide_fault && rsp_result_kind) |->
      rsp_compensated_value == 32'h7FFF_FFFF) else $error("bad saturation");
endmodule

bind barometric_pressure_compensation bpc_checker u_bpc_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_compensated_value(rsp_compensated_value),
   .rsp_divide_fault(rsp_divide_fault), .rsp_result_kind(rsp_result_kind));
`default_nettype wire

// File: dv/barometric_pressure_compensation_tb.sv
// barometric_pressure_compensation_tb: self-checking bench for the compensation block
// predicts each temperature and pressure result in 32-bit wrapping integer arithmetic
// depends on bpc_pkg and barometric_pressure_compensation
`timescale 1ns / 100ps
`default_nettype none
module barometric_pressure_compensation_tb;

   typedef struct {
      logic        opcode;
      logic [15:0] raw;
   } reading_item_type;

   typedef struct {
      logic        kind;
      logic [31:0] value;
      logic        fault;
   } compensated_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_opcode;
   logic [15:0] req_raw_reading;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_result_kind;
   logic [31:0] rsp_compensated_value;
   logic        rsp_divide_fault;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [4:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   reading_item_type pending_q[$];
   compensated_type  expected_q[$];
   logic [31:0]   cal_words[5];
   logic [31:0]   stored_b5;
   int            error_count;
   int            send_gap;
   int            recv_gap;
   int            hold_left;
   bit            hold_start;
   bit            hold_done;
   bit            quiet;

   barometric_pressure_compensation u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_opcode(req_opcode), .req_raw_reading(req_raw_reading),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result_kind(rsp_result_kind),
      .rsp_compensated_value(rsp_compensated_value),
      .rsp_divide_fault(rsp_divide_fault),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // clock
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // arithmetic helpers
   function automatic logic [31:0] sext16(logic [15:0] h);
      return {{16{h[15]}}, h};
   endfunction

   function automatic logic [31:0] asr(logic [31:0] v, int n);
      logic signed [31:0] s;
      s = $signed(v);
      s = s >>> n;
      return s;
   endfunction

   // compensation of one reading; a temperature with a nonzero divisor updates the stored b5 term
   function automatic compensated_type compensate(reading_item_type it);
      compensated_type r;
      logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
      logic [31:0] x1, x2, x3, num, den, b3, b4, b5, b6, b7, sq, p, raw32;
      longint q;
      ac1 = sext16(cal_words[bpc_pkg::REG_AC1_AC2][31:16]);
      ac2 = sext16(cal_words[bpc_pkg::REG_AC1_AC2][15:0]);
      ac3 = sext16(cal_words[bpc_pkg::REG_AC3_AC4][31:16]);
      ac4 = {16'd0, cal_words[bpc_pkg::REG_AC3_AC4][15:0]};
      ac5 = {16'd0, cal_words[bpc_pkg::REG_AC5_AC6][31:16]};
      ac6 = {16'd0, cal_words[bpc_pkg::REG_AC5_AC6][15:0]};
      b1  = sext16(cal_words[bpc_pkg::REG_B1_B2][31:16]);
      b2  = sext16(cal_words[bpc_pkg::REG_B1_B2][15:0]);
      mc  = sext16(cal_words[bpc_pkg::REG_MC_MD][31:16]);
      md  = sext16(cal_words[bpc_pkg::REG_MC_MD][15:0]);
      raw32 = {16'd0, it.raw};
      r.kind = it.opcode;
      r.fault = 1'b0;
      if (it.opcode == bpc_pkg::OP_TEMP) begin
         x1 = asr((raw32 - ac6) * ac5, 15);
         num = mc * 32'd2048;
         den = x1 + md;
         if (den == 32'd0) begin
            r.fault = 1'b1;
            r.value = num[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end else begin
            q = longint'($signed(num)) / longint'($signed(den));
            x2 = q[31:0];
            b5 = x1 + x2;
            stored_b5 = b5;
            r.value = asr(b5 + 32'd8, 4);
         end
      end else begin
         b6 = stored_b5 - 32'd4000;
         sq = asr(b6 * b6, 12);
         x1 = asr(b2 * sq, 11);
         x2 = asr(ac2 * b6, 11);
         x3 = x1 + x2;
         b3 = asr(ac1 * 32'd4 + x3 + 32'd2, 2);
         x1 = asr(ac3 * b6, 13);
         x2 = asr(b1 * sq, 16);
         x3 = asr(x1 + x2 + 32'd2, 2);
         b4 = (ac4 * (x3 + 32'd32768)) >> 15;
         b7 = (raw32 - b3) * 32'd50000;
         if (b4 == 32'd0) begin
            r.fault = 1'b1;
            r.value = 32'h7FFF_FFFF;
         end else begin
            if (b7[31]) p = (b7 / b4) << 1;
            else p = (b7 << 1) / b4;
            x1 = asr(p, 8);
            x1 = x1 * x1;
            x1 = asr(x1 * 32'd3038, 16);
            x2 = asr(p * (32'd0 - 32'd7357), 16);
            r.value = p + asr(x1 + x2 + 32'd3791, 4);
         end
      end
      return r;
   endfunction

   function automatic int draw_gap();
      if (quiet || $urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 16);
   endfunction

   task automatic report(string what, logic [31:0] exp_v, logic [31:0] got_v);
      $display("mismatch %s: expected %h got %h at %0t", what, exp_v, got_v, $realtime);
      error_count++;
   endtask

   // driver: offers pending items, predicts at acceptance
   always @(posedge clock) begin
      reading_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
         req_opcode <= 1'b0;
         req_raw_reading <= 16'd0;
         send_gap <= 0;
      end else if (!(req_valid && !req_ready)) begin
         if (req_valid) expected_q.push_back(compensate('{req_opcode, req_raw_reading}));
         if (send_gap != 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_q.size() != 0) begin
            it = pending_q.pop_front();
            req_valid <= 1'b1;
            req_opcode <= it.opcode;
            req_raw_reading <= it.raw;
            send_gap <= draw_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_start && !hold_done) begin
         hold_left <= 2000;
         hold_done <= 1'b1;
      end
   end

   // monitor: checks each accepted item against the oldest prediction
   always @(posedge clock) begin
      compensated_type e;
      int gap;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap <= 0;
      end else begin
         gap = recv_gap;
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report("unexpected item", 32'd0, rsp_compensated_value);
            end else begin
               e = expected_q.pop_front();
               if (rsp_result_kind !== e.kind)
                  report("result_kind", 32'(e.kind), 32'(rsp_result_kind));
               if (rsp_compensated_value !== e.value)
                  report("compensated_value", e.value, rsp_compensated_value);
               if (rsp_divide_fault !== e.fault)
                  report("divide_fault", 32'(e.fault), 32'(rsp_divide_fault));
            end
            gap = draw_gap();
         end else if (gap != 0) begin
            gap = gap - 1;
         end
         recv_gap <= gap;
         rsp_ready <= (gap == 0) && (hold_left == 0);
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [31:0] v);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      cal_words[idx] = v;
   endtask

   task automatic write_all(logic [31:0] w0, logic [31:0] w1, logic [31:0] w2,
                            logic [31:0] w3, logic [31:0] w4);
      csr_write(bpc_pkg::REG_AC1_AC2, w0);
      csr_write(bpc_pkg::REG_AC3_AC4, w1);
      csr_write(bpc_pkg::REG_AC5_AC6, w2);
      csr_write(bpc_pkg::REG_B1_B2, w3);
      csr_write(bpc_pkg::REG_MC_MD, w4);
   endtask

   task automatic push(logic op, logic [15:0] raw);
      pending_q.push_back('{op, raw});
   endtask

   // wait until every item has been sent and answered
   task automatic drain();
      do @(negedge clock);
      while (pending_q.size() != 0 || req_valid || expected_q.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   function automatic logic [15:0] jitter(int base, int span);
      return 16'(base + $urandom_range(0, 2 * span) - span);
   endfunction

   task automatic random_config();
      case ($urandom_range(0, 3))
         0, 1: write_all({jitter(408, 300), jitter(-72, 100)},
                         {jitter(-14383, 2000), jitter(32741, 2000)},
                         {jitter(32757, 2000), jitter(23153, 2000)},
                         {jitter(6190, 1000), jitter(4, 8)},
                         {jitter(-8711, 1000), jitter(2868, 500)});
         2: write_all($urandom, $urandom, $urandom, $urandom, $urandom);
         default: write_all(32'hFFFF_FFFF, 32'h8000_FFFF, 32'hFFFF_0000,
                            32'h7FFF_8000, 32'h8000_7FFF);
      endcase
   endtask

   // random items: mostly a temperature followed by pressures
   task automatic random_items(int n);
      int k;
      k = 0;
      while (k < n) begin
         if ($urandom_range(0, 9) < 7) begin
            push(bpc_pkg::OP_TEMP, jitter(27898, 3000));
            k++;
            repeat ($urandom_range(1, 3)) begin
               push(bpc_pkg::OP_PRESS,
                    $urandom_range(0, 3) == 0 ? 16'($urandom) : jitter(23843, 4000));
               k++;
            end
         end else begin
            push(1'($urandom), 16'($urandom));
            k++;
         end
      end
   endtask

   // stimulus
   initial begin
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = 5'd0;
      pwdata = 32'd0;
      error_count = 0;
      stored_b5 = 32'd0;
      hold_start = 1'b0;
      quiet = 1'b0;
      foreach (cal_words[i]) cal_words[i] = 32'd0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset calibration: pressure before any temperature, both divisors zero
      push(bpc_pkg::OP_PRESS, 16'd0);
      push(bpc_pkg::OP_TEMP, 16'hFFFF);
      push(bpc_pkg::OP_PRESS, 16'hFFFF);
      drain();
      // negative numerator with zero temperature divisor
      write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'h8000_0000);
      push(bpc_pkg::OP_TEMP, 16'd0);
      push(bpc_pkg::OP_TEMP, 16'h8000);
      drain();
      // typical factory calibration and field extremes
      write_all({16'd408, 16'hFFB8}, {16'hC7D1, 16'd32741}, {16'd32757, 16'd23153},
                {16'd6190, 16'd4}, {16'hDDF9, 16'd2868});
      push(bpc_pkg::OP_TEMP, 16'd27898);
      push(bpc_pkg::OP_PRESS, 16'd23843);
      push(bpc_pkg::OP_TEMP, 16'd0);
      push(bpc_pkg::OP_PRESS, 16'd0);
      push(bpc_pkg::OP_PRESS, 16'hFFFF);
      push(bpc_pkg::OP_TEMP, 16'hFFFF);
      push(bpc_pkg::OP_PRESS, 16'h8000);
      push(bpc_pkg::OP_TEMP, 16'h7FFF);
      push(bpc_pkg::OP_PRESS, 16'h7FFF);
      drain();
      // all ones
      write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF);
      push(bpc_pkg::OP_TEMP, 16'h5555);
      push(bpc_pkg::OP_PRESS, 16'hAAAA);
      push(bpc_pkg::OP_TEMP, 16'hAAAA);
      push(bpc_pkg::OP_PRESS, 16'h5555);
      drain();

      for (int ph = 0; ph < 10; ph++) begin
         quiet = (ph % 4 == 3);
         random_config();
         if (ph == 5) hold_start = 1'b1;
         random_items(140);
         drain();
      end

      repeat (500) @(negedge clock);
      if (error_count == 0 && expected_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // run limit
   initial begin
      #20000000;
      $display("status: fail");
      $finish;
   end
endmodule
`default_nettype wire

// File: filelist.f
hw/rtl/bpc_pkg.sv
hw/rtl/bpc_mul.sv
hw/rtl/bpc_div.sv
hw/rtl/barometric_pressure_compensation.sv
hw/rtl/bpc_checker.sv
dv/barometric_pressure_compensation_tb.sv
